/* hdl/twpd_pkg.sv */
// shared types and constants for the three-window peak detector
// no dependencies

package twpd_pkg;

  // register indexes on the configuration port
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_MARGIN = 1'd1;

  localparam int unsigned CFG_DATA_W = 15;
  localparam int unsigned WIN_W      = 7;
  localparam int unsigned MARGIN_W   = 15;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned SUM_W      = 24;
  localparam int unsigned OUT_IDX_W  = 16;

  // operand width of the shared compare unit, covers sum plus margin*window
  localparam int unsigned CMP_W = 32;

  typedef struct packed {
    logic signed [CMP_W-1:0] lhs;
    logic signed [CMP_W-1:0] rhs;
    logic        [CMP_W-1:0] bias;
  } cmp_req_t;

endpackage

/* hdl/twpd_ram.sv */
// generic single-write, single-read memory with registered read data
// no dependencies

module twpd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/twpd_cmp.sv */
// shared signed compare unit: lhs > rhs + bias
// depends on twpd_pkg

module twpd_cmp (
  input  twpd_pkg::cmp_req_t req_i,
  output logic               gt_o
);

  import twpd_pkg::*;

  logic signed [CMP_W:0] rhs_sum;

  always_comb begin
    rhs_sum = (CMP_W+1)'(req_i.rhs) + $signed({1'b0, req_i.bias});
    gt_o    = (CMP_W+1)'(req_i.lhs) > rhs_sum;
  end

endmodule

/* hdl/three_window_peak_detector.sv */
// three-window peak detector: samples are accepted only in idle; each then takes three reads
// on the single read port of the delay-line memory and one update, then the trail test on
// the one compare unit and, when it passes, the lead test. a last beat then loads the output
// register, waiting while the previous report is held; beats after a detection are dropped.
// a detection adds the scan reads of the span, a wait for read latency, a state to form the
// index and one to load the output. reset clears control, counters and sums, not the line.

module three_window_peak_detector #(
  parameter int unsigned MAX_WINDOW = 64,
  parameter int unsigned INDEX_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [twpd_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [twpd_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [twpd_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                 last_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 found_o,
  output logic [twpd_pkg::OUT_IDX_W-1:0]       peak_index_o
);

  import twpd_pkg::*;

  localparam int unsigned DEPTH = 3 * MAX_WINDOW;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned SBITS = $clog2(DEPTH + 1);
  localparam int unsigned WBITS = $clog2(MAX_WINDOW + 1);
  localparam int unsigned TW    = MARGIN_W + WBITS;
  localparam int unsigned CMPW  = (INDEX_BITS > SBITS) ? INDEX_BITS : SBITS;
  localparam logic [INDEX_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [10:0] {
    S_IDLE      = 11'b000_0000_0001,
    S_RD_LEAD   = 11'b000_0000_0010,
    S_RD_MID    = 11'b000_0000_0100,
    S_RD_TRAIL  = 11'b000_0000_1000,
    S_UPDATE    = 11'b000_0001_0000,
    S_CMP_TRAIL = 11'b000_0010_0000,
    S_CMP_LEAD  = 11'b000_0100_0000,
    S_SCAN      = 11'b000_1000_0000,
    S_SCAN_END  = 11'b001_0000_0000,
    S_LOCATE    = 11'b010_0000_0000,
    S_EMIT      = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [WIN_W-1:0]    window_len_q, window_len_d;
  logic [MARGIN_W-1:0] peak_margin_q, peak_margin_d;

  logic signed [SAMPLE_W-1:0] sample_q, sample_d;
  logic                       last_q, last_d;
  logic [TW-1:0]              thr_q, thr_d;
  logic [AW-1:0]              wr_ptr_q, wr_ptr_d;
  logic [INDEX_BITS-1:0]      count_q, count_d;
  logic signed [SUM_W-1:0]    lead_q, lead_d, mid_q, mid_d, trail_q, trail_d;
  logic                       frame_done_q, frame_done_d;
  logic signed [SAMPLE_W-1:0] out_lead_q, out_lead_d, out_mid_q, out_mid_d;

  logic [AW-1:0]              scan_addr_q, scan_addr_d;
  logic [SBITS-1:0]           scan_n_q, scan_n_d;
  logic                       rd_pend_q, rd_pend_d;
  logic [SBITS-1:0]           rd_j_q, rd_j_d;
  logic signed [SAMPLE_W-1:0] best_val_q, best_val_d;
  logic [SBITS-1:0]           best_j_q, best_j_d;

  logic                 res_found_q, res_found_d;
  logic [OUT_IDX_W-1:0] res_index_q, res_index_d;
  logic                 out_valid_q, out_valid_d;
  logic                 found_q, found_d;
  logic [OUT_IDX_W-1:0] index_q, index_d;

  // memory and compare unit hookup
  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [SAMPLE_W-1:0] ram_rdata;
  cmp_req_t            cmp_req;
  logic                cmp_gt;

  logic [WBITS-1:0]     w_eff;
  logic [SBITS-1:0]     w1, w2, w3;
  logic signed [SAMPLE_W-1:0] rd_sample, out_trail;
  logic [CMPW-1:0]      pos;
  logic [CMPW+OUT_IDX_W-1:0] pos_ext, cnt_ext;
  logic                 in_accept;

  function automatic logic [AW-1:0] ptr_sub(input logic [AW-1:0] p, input logic [SBITS-1:0] o);
    logic [SBITS:0] t;
    t = (SBITS+1)'(p) - {1'b0, o};
    if (t[SBITS]) begin
      t = t + (SBITS+1)'(DEPTH);
    end
    return t[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic cnt_ge(input logic [INDEX_BITS-1:0] c, input logic [SBITS-1:0] v);
    return CMPW'(c) >= CMPW'(v);
  endfunction

  // window length 0 acts as 1, above the limit acts as the limit
  always_comb begin
    if (window_len_q == '0) begin
      w_eff = WBITS'(1);
    end else if (int'(window_len_q) > int'(MAX_WINDOW)) begin
      w_eff = WBITS'(MAX_WINDOW);
    end else begin
      w_eff = WBITS'(window_len_q);
    end
    w1 = SBITS'(w_eff);
    w2 = w1 + w1;
    w3 = w2 + w1;
  end

  twpd_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (sample_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  twpd_cmp u_cmp (
    .req_i (cmp_req),
    .gt_o  (cmp_gt)
  );

  assign rd_sample = $signed(ram_rdata);
  assign in_accept = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);

  // the compare unit serves the scan while a read is in flight, else the threshold tests
  always_comb begin
    if (rd_pend_q) begin
      cmp_req.lhs  = CMP_W'(rd_sample);
      cmp_req.rhs  = CMP_W'(best_val_q);
      cmp_req.bias = '0;
    end else if (state_q == S_CMP_TRAIL) begin
      cmp_req.lhs  = CMP_W'(mid_q);
      cmp_req.rhs  = CMP_W'(trail_q);
      cmp_req.bias = CMP_W'(thr_q);
    end else begin
      cmp_req.lhs  = CMP_W'(mid_q);
      cmp_req.rhs  = CMP_W'(lead_q);
      cmp_req.bias = CMP_W'(thr_q);
    end
  end

  always_comb begin
    pos     = CMPW'(count_q) - CMPW'(w3) + CMPW'(best_j_q);
    pos_ext = {{OUT_IDX_W{1'b0}}, pos};
    cnt_ext = {{OUT_IDX_W{1'b0}}, CMPW'(count_q)};
    out_trail = cnt_ge(count_q, w3) ? rd_sample : '0;
  end

  always_comb begin
    state_d       = state_q;
    window_len_d  = window_len_q;
    peak_margin_d = peak_margin_q;
    sample_d      = sample_q;
    last_d        = last_q;
    thr_d         = thr_q;
    wr_ptr_d      = wr_ptr_q;
    count_d       = count_q;
    lead_d        = lead_q;
    mid_d         = mid_q;
    trail_d       = trail_q;
    frame_done_d  = frame_done_q;
    out_lead_d    = out_lead_q;
    out_mid_d     = out_mid_q;
    scan_addr_d   = scan_addr_q;
    scan_n_d      = scan_n_q;
    rd_pend_d     = (state_q == S_SCAN);
    rd_j_d        = rd_j_q;
    best_val_d    = best_val_q;
    best_j_d      = best_j_q;
    res_found_d   = res_found_q;
    res_index_d   = res_index_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    found_d       = found_q;
    index_d       = index_q;
    ram_we        = 1'b0;
    ram_waddr     = wr_ptr_q;
    ram_raddr     = scan_addr_q;

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_WINDOW_LEN: begin
          window_len_d = cfg_data_i[WIN_W-1:0];
          count_d      = '0;
          lead_d       = '0;
          mid_d        = '0;
          trail_d      = '0;
          frame_done_d = 1'b0;
        end
        REG_PEAK_MARGIN: peak_margin_d = cfg_data_i[MARGIN_W-1:0];
        default: ;
      endcase
    end

    // scan compare stage, one sample per cycle behind the read
    if (rd_pend_q && ((rd_j_q == '0) || cmp_gt)) begin
      best_val_d = rd_sample;
      best_j_d   = rd_j_q;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          sample_d = sample_i;
          last_d   = last_i;
          thr_d    = TW'(peak_margin_q * w_eff);
          if (frame_done_q) begin
            if (last_i) begin
              count_d      = '0;
              lead_d       = '0;
              mid_d        = '0;
              trail_d      = '0;
              frame_done_d = 1'b0;
            end
          end else begin
            state_d = S_RD_LEAD;
          end
        end
      end
      S_RD_LEAD: begin
        ram_raddr = ptr_sub(wr_ptr_q, w1);
        state_d   = S_RD_MID;
      end
      S_RD_MID: begin
        ram_raddr  = ptr_sub(wr_ptr_q, w2);
        out_lead_d = cnt_ge(count_q, w1) ? rd_sample : '0;
        state_d    = S_RD_TRAIL;
      end
      S_RD_TRAIL: begin
        ram_raddr = ptr_sub(wr_ptr_q, w3);
        out_mid_d = cnt_ge(count_q, w2) ? rd_sample : '0;
        state_d   = S_UPDATE;
      end
      S_UPDATE: begin
        lead_d   = lead_q + SUM_W'(sample_q) - SUM_W'(out_lead_q);
        mid_d    = mid_q + SUM_W'(out_lead_q) - SUM_W'(out_mid_q);
        trail_d  = trail_q + SUM_W'(out_mid_q) - SUM_W'(out_trail);
        ram_we   = 1'b1;
        wr_ptr_d = ptr_inc(wr_ptr_q);
        if (count_q != COUNT_MAX) begin
          count_d = count_q + 1'b1;
        end
        state_d = S_CMP_TRAIL;
      end
      S_CMP_TRAIL, S_CMP_LEAD: begin
        if (cnt_ge(count_q, w3) && cmp_gt) begin
          if (state_q == S_CMP_TRAIL) begin
            state_d = S_CMP_LEAD;
          end else begin
            // scan starts at the oldest sample of the span
            scan_addr_d = ptr_sub(wr_ptr_q, w3);
            scan_n_d    = '0;
            state_d     = S_SCAN;
          end
        end else if (last_q) begin
          res_found_d = 1'b0;
          res_index_d = cnt_ext[OUT_IDX_W-1:0];
          state_d     = S_EMIT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        ram_raddr   = scan_addr_q;
        scan_addr_d = ptr_inc(scan_addr_q);
        scan_n_d    = scan_n_q + 1'b1;
        rd_j_d      = scan_n_q;
        if (scan_n_q == w3 - 1'b1) begin
          state_d = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        state_d = S_LOCATE;
      end
      S_LOCATE: begin
        res_found_d = 1'b1;
        res_index_d = pos_ext[OUT_IDX_W-1:0];
        state_d     = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          found_d     = res_found_q;
          index_d     = res_index_q;
          if (last_q) begin
            count_d      = '0;
            lead_d       = '0;
            mid_d        = '0;
            trail_d      = '0;
            frame_done_d = 1'b0;
          end else begin
            frame_done_d = 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      window_len_q  <= WIN_W'(4);
      peak_margin_q <= MARGIN_W'(768);
      wr_ptr_q      <= '0;
      count_q       <= '0;
      lead_q        <= '0;
      mid_q         <= '0;
      trail_q       <= '0;
      frame_done_q  <= 1'b0;
      rd_pend_q     <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      window_len_q  <= window_len_d;
      peak_margin_q <= peak_margin_d;
      wr_ptr_q      <= wr_ptr_d;
      count_q       <= count_d;
      lead_q        <= lead_d;
      mid_q         <= mid_d;
      trail_q       <= trail_d;
      frame_done_q  <= frame_done_d;
      rd_pend_q     <= rd_pend_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q    <= sample_d;
    last_q      <= last_d;
    thr_q       <= thr_d;
    out_lead_q  <= out_lead_d;
    out_mid_q   <= out_mid_d;
    scan_addr_q <= scan_addr_d;
    scan_n_q    <= scan_n_d;
    rd_j_q      <= rd_j_d;
    best_val_q  <= best_val_d;
    best_j_q    <= best_j_d;
    res_found_q <= res_found_d;
    res_index_q <= res_index_d;
    found_q     <= found_d;
    index_q     <= index_d;
  end

  assign out_valid_o  = out_valid_q;
  assign found_o      = found_q;
  assign peak_index_o = index_q;

  // every sum update writes one sample and moves the write pointer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_UPDATE |=> wr_ptr_q != $past(wr_ptr_q))
    else $error("write pointer did not advance after a sample update");

  // the chosen peak lies inside the three-window span
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOCATE |-> best_j_q < w3)
    else $error("peak offset outside the span");

  // a detection that is not on the last beat closes the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_valid_d && !out_valid_q && res_found_q && !last_q && !cfg_we_i)
      |=> frame_done_q)
    else $error("frame not closed after a detection");

  // a scan is only entered with a full span in the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == S_SCAN) |-> cnt_ge(count_q, w3))
    else $error("scan started before the span was full");

endmodule

/* tb/sv/three_window_peak_detector_test.sv */
// self-checking testbench for the three-window peak detector
// depends on twpd_pkg and three_window_peak_detector; drives random handshake gaps on both sides

module three_window_peak_detector_test;
  timeunit 1ns;
  timeprecision 1ps;

  import twpd_pkg::*;

  localparam int unsigned MAX_WIN        = 64;
  localparam int unsigned LINE_LEN       = 3 * MAX_WIN;
  localparam int unsigned COUNT_TOP      = 65535;
  localparam int unsigned TOTAL_BEATS    = 1550;
  localparam int unsigned SETTLE_CYCLES  = 250;
  localparam int unsigned QUIET_LIMIT    = 4000;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } beat_t;

  typedef struct {
    logic                 found;
    logic [OUT_IDX_W-1:0] index;
  } report_t;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]      cfg_data_i  = '0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_ready_o;
  logic signed [SAMPLE_W-1:0] sample_i    = '0;
  logic                       last_i      = 1'b0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic                       found_o;
  logic [OUT_IDX_W-1:0]       peak_index_o;

  // expected peak reports and pending sample beats
  beat_t   sample_q[$];
  report_t peak_q[$];
  beat_t   shown;

  // predictor state
  logic signed [SAMPLE_W-1:0] history [LINE_LEN];
  int                         trail_acc;
  int                         mid_acc;
  int                         lead_sum;
  int unsigned                frame_count;
  bit                         peak_taken;
  logic [WIN_W-1:0]           win_len = 7'd4;
  logic [MARGIN_W-1:0]        margin  = 15'd768;

  int unsigned samples_scored;
  int unsigned beats_queued;
  int unsigned fail_count;
  int unsigned found_count;
  int unsigned miss_count;
  int unsigned quiet_cycles;
  int unsigned gap_left;
  int unsigned stall_left;
  bit          gaps_on = 1'b1;

  three_window_peak_detector u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_i     (sample_i),
    .last_i       (last_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .found_o      (found_o),
    .peak_index_o (peak_index_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic int unsigned eff_win();
    if (win_len == 0) return 1;
    if (win_len > MAX_WIN) return MAX_WIN;
    return win_len;
  endfunction

  function automatic void restart_frame();
    trail_acc   = 0;
    mid_acc     = 0;
    lead_sum    = 0;
    frame_count = 0;
    peak_taken  = 1'b0;
  endfunction

  function automatic void predict_peak(beat_t b);
    int unsigned w;
    int unsigned span;
    int unsigned best;
    int          drop_lead;
    int          drop_mid;
    int          drop_trail;
    longint      bar;
    longint      pos;
    bit          hit;
    report_t     r;
    w    = eff_win();
    span = 3 * w;
    hit  = 1'b0;
    if (!peak_taken) begin
      samples_scored++;
      drop_lead  = (frame_count >= w) ? int'(history[w-1]) : 0;
      drop_mid   = (frame_count >= 2 * w) ? int'(history[2*w-1]) : 0;
      drop_trail = (frame_count >= span) ? int'(history[span-1]) : 0;
      lead_sum   += b.sample - drop_lead;
      mid_acc    += drop_lead - drop_mid;
      trail_acc  += drop_mid - drop_trail;
      for (int i = LINE_LEN - 1; i > 0; i--) history[i] = history[i-1];
      history[0] = b.sample;
      if (frame_count < COUNT_TOP) frame_count++;
      if (frame_count >= span) begin
        bar = longint'(margin) * longint'(w);
        if (longint'(mid_acc) > longint'(trail_acc) + bar &&
            longint'(mid_acc) > longint'(lead_sum) + bar) begin
          // oldest sample wins a tie
          best = span - 1;
          for (int i = int'(span) - 2; i >= 0; i--) begin
            if (history[i] > history[best]) best = i;
          end
          pos = longint'(frame_count - span + (span - 1 - best));
          if (pos > COUNT_TOP) pos = COUNT_TOP;
          r.found = 1'b1;
          r.index = pos[OUT_IDX_W-1:0];
          peak_q = {peak_q, r};
          peak_taken = 1'b1;
          hit = 1'b1;
        end
      end
      if (b.last && !hit) begin
        r.found = 1'b0;
        r.index = frame_count[OUT_IDX_W-1:0];
        peak_q = {peak_q, r};
      end
    end
    if (b.last) restart_frame();
  endfunction

  function automatic void push_beat(logic signed [SAMPLE_W-1:0] s, logic lst);
    beat_t b;
    b.sample = s;
    b.last   = lst;
    sample_q = {sample_q, b};
    beats_queued++;
  endfunction

  // noise, flat or bump-shaped frame content
  function automatic void queue_frame(int unsigned len, int unsigned w, bit closed);
    int unsigned kind;
    int unsigned bump_at;
    int          base;
    int          amp;
    int          level;
    kind    = $urandom_range(0, 9);
    base    = int'($urandom_range(0, 4000)) - 2000;
    amp     = ($urandom_range(0, 3) == 0) ? -int'($urandom_range(0, 20000))
                                          : int'($urandom_range(0, 24000));
    bump_at = (len > w) ? $urandom_range(0, len - w) : 0;
    for (int unsigned k = 0; k < len; k++) begin
      if (kind < 2) begin
        level = int'($urandom_range(0, 65535)) - 32768;
      end else begin
        level = base + int'($urandom_range(0, 126)) - 63;
        if (kind >= 3 && k >= bump_at && k < bump_at + w) level += amp;
        if (level > 32767) level = 32767;
        if (level < -32768) level = -32768;
      end
      push_beat(level[SAMPLE_W-1:0], closed && (k == len - 1));
    end
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_WINDOW_LEN) begin
      win_len = data[WIN_W-1:0];
      restart_frame();
    end else begin
      margin = data[MARGIN_W-1:0];
    end
  endtask

  // block may still be busy with the last accepted beat after the queues drain, so hold off a while
  task automatic settle();
    while (sample_q.size() != 0 || in_valid_i || peak_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // sample driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid_i && in_ready_o) predict_peak(shown);
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0 || sample_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid_i <= 1'b0;
        end else begin
          shown = sample_q.pop_front();
          in_valid_i <= 1'b1;
          sample_i   <= shown.sample;
          last_i     <= shown.last;
          gap_left = gaps_on ? $urandom_range(0, 15) : 0;
        end
      end
    end
  end

  // report monitor
  always @(posedge clk_i or negedge rst_ni) begin
    report_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (peak_q.size() == 0) begin
          $error("report with nothing expected: found %0d, peak_index %0d",
                 found_o, peak_index_o);
          fail_count++;
        end else begin
          want = peak_q.pop_front();
          if (found_o !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, found_o);
            fail_count++;
          end
          if (peak_index_o !== want.index) begin
            $error("peak_index: expected %0d, actual %0d", want.index, peak_index_o);
            fail_count++;
          end
          if (want.found) found_count++;
          else miss_count++;
        end
        stall_left = gaps_on ? $urandom_range(0, 15) : 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned      phase;
    int unsigned      w;
    int unsigned      span;
    int unsigned      frames;
    int unsigned      len;
    int unsigned      pick;
    logic [WIN_W-1:0] new_win;
    logic [14:0]      new_margin;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: rail-to-rail bump that only shows on the last beat
    for (int k = 0; k < 4; k++) push_beat(16'sh8000, 1'b0);
    for (int k = 0; k < 4; k++) push_beat(16'sh7FFF, 1'b0);
    for (int k = 0; k < 4; k++) push_beat(16'sh8000, k == 3);
    // frame shorter than three windows
    push_beat(16'sd1, 1'b0);
    push_beat(-16'sd1, 1'b0);
    push_beat(16'sd0, 1'b1);
    settle();

    // zero window acts as one; beats after the detection are dropped
    write_reg(REG_WINDOW_LEN, 15'd0);
    write_reg(REG_PEAK_MARGIN, 15'd0);
    push_beat(-16'sd1, 1'b0);
    push_beat(16'sd5, 1'b0);
    push_beat(-16'sd1, 1'b0);
    push_beat(16'sd9, 1'b0);
    push_beat(16'sd9, 1'b1);
    push_beat(16'sd7, 1'b1);
    settle();

    phase = 0;
    while (beats_queued < TOTAL_BEATS) begin
      case (phase)
        0: begin
          new_win    = 7'd127;
          new_margin = 15'd32767;
        end
        1: begin
          new_win    = 7'd1;
          new_margin = 15'd0;
        end
        default: begin
          pick = $urandom_range(0, 19);
          if (pick == 0) new_win = 7'd0;
          else if (pick == 1) new_win = 7'd64;
          else if (pick == 2) new_win = 7'($urandom_range(65, 127));
          else if (pick == 3) new_win = 7'd1;
          else if (pick < 10) new_win = 7'($urandom_range(2, 4));
          else new_win = 7'($urandom_range(1, 12));
          pick = $urandom_range(0, 7);
          if (pick == 0) new_margin = 15'd0;
          else if (pick == 1) new_margin = 15'd32767;
          else if (pick == 2) new_margin = 15'($urandom_range(0, 32767));
          else new_margin = 15'($urandom_range(0, 1500));
        end
      endcase
      // margin-only writes keep an open frame going
      pick = (phase < 2) ? 2 : $urandom_range(0, 3);
      if (pick != 1) write_reg(REG_WINDOW_LEN, 15'(new_win));
      if (pick != 0) write_reg(REG_PEAK_MARGIN, new_margin);
      gaps_on = ($urandom_range(0, 3) != 0);

      w      = eff_win();
      span   = 3 * w;
      frames = (w >= 32) ? 1 : $urandom_range(2, 6);
      for (int unsigned f = 0; f < frames; f++) begin
        if ($urandom_range(0, 7) == 0) len = $urandom_range(1, span - 1);
        else len = span + $urandom_range(0, 4 * w + 4);
        queue_frame(len, w, !(f == frames - 1 && $urandom_range(0, 3) == 0));
      end
      settle();
      phase++;
    end

    $display("covered %0d beats, %0d scored, over %0d setting changes: %0d peaks, %0d misses",
             beats_queued, samples_scored, phase + 2, found_count, miss_count);
    $display("window lengths 0 to 127, margins 0 to 32767, short, open and gapless frames");
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/twpd_pkg.sv
hdl/twpd_ram.sv
hdl/twpd_cmp.sv
hdl/three_window_peak_detector.sv
tb/sv/three_window_peak_detector_test.sv
